### rtl/bwd_pkg.sv
// ----------------------------------------------------------------------------
// bwd_pkg
// Shared types and constants of the blit word datapath.
// ----------------------------------------------------------------------------
package bwd_pkg;

   localparam int WordWidth = 16;
   localparam int ColWidth  = 6;
   localparam int RowWidth  = 10;
   localparam int IdxWidth  = 3;

   typedef enum logic [IdxWidth-1:0] {
      REG_CONTROL_ZERO = 3'd0,
      REG_CONTROL_ONE  = 3'd1,
      REG_FIRST_MASK   = 3'd2,
      REG_LAST_MASK    = 3'd3,
      REG_BLIT_SIZE    = 3'd4,
      REG_A_PRELOAD    = 3'd5,
      REG_B_PRELOAD    = 3'd6,
      REG_C_PRELOAD    = 3'd7
   } bwd_reg_type;

   // control_zero bit positions
   localparam int C0_USE_A = 11;
   localparam int C0_USE_B = 10;
   localparam int C0_USE_C = 9;
   localparam int C0_USE_D = 8;
   // control_one bit positions
   localparam int C1_EXCL  = 4;
   localparam int C1_INCL  = 3;
   localparam int C1_FCI   = 2;
   localparam int C1_DESC  = 1;

   typedef struct packed {
      logic [WordWidth-1:0] control_zero;
      logic [WordWidth-1:0] control_one;
      logic [WordWidth-1:0] first_mask;
      logic [WordWidth-1:0] last_mask;
      logic [WordWidth-1:0] blit_size;
      logic [WordWidth-1:0] a_preload;
      logic [WordWidth-1:0] b_preload;
      logic [WordWidth-1:0] c_preload;
   } bwd_cfg_type;

   // One classified word on its way from the front to the back.
   typedef struct packed {
      logic [WordWidth-1:0] a_val;
      logic [WordWidth-1:0] b_val;
      logic [WordWidth-1:0] c_val;
      logic                 blit_start;
      logic                 row_start;
      logic                 row_end;
      logic                 last;
   } bwd_item_type;

endpackage

### rtl/bwd_front.sv
// ----------------------------------------------------------------------------
// bwd_front
// Accepts fetched words, tracks position, masks and shifts A and B.
// ----------------------------------------------------------------------------
module bwd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  bwd_pkg::bwd_cfg_type  cfg,
   input  logic                  size_write,
   input  logic                  req_valid,
   input  logic [15:0]           req_a_word,
   input  logic [15:0]           req_b_word,
   input  logic [15:0]           req_c_word,
   input  logic                  queue_full,
   output logic                  push,
   output bwd_pkg::bwd_item_type push_item
);
   import bwd_pkg::*;

   logic [ColWidth-1:0]  column_ff, column_in;
   logic [RowWidth-1:0]  row_ff, row_in;
   logic [WordWidth-1:0] prev_a_ff, prev_a_in, prev_b_ff, prev_b_in;
   logic [WordWidth-1:0] hold_a_ff, hold_a_in, hold_b_ff, hold_b_in, hold_c_ff, hold_c_in;
   logic [ColWidth-1:0]  col_last;
   logic [RowWidth-1:0]  row_last;
   logic                 start, row_start, rend, lst, desc;
   logic [WordWidth-1:0] prev_a_eff, prev_b_eff, a_masked;

   function automatic logic [WordWidth-1:0] shift_pair(
      input logic [WordWidth-1:0] cur,
      input logic [WordWidth-1:0] old,
      input logic [3:0]           sh,
      input logic                 dsc
   );
      logic [2*WordWidth-1:0] pair;
      logic [4:0]             amt;
      if (sh == 4'd0) begin
         return cur;
      end
      if (dsc) begin
         pair = {cur, old};
         amt  = 5'd16 - {1'b0, sh};
      end else begin
         pair = {old, cur};
         amt  = {1'b0, sh};
      end
      pair = pair >> amt;
      return pair[WordWidth-1:0];
   endfunction

   assign push      = req_valid & ~queue_full;
   assign col_last  = cfg.blit_size[ColWidth-1:0] - ColWidth'(1);
   assign row_last  = cfg.blit_size[WordWidth-1:ColWidth] - RowWidth'(1);
   assign row_start = (column_ff == '0);
   assign start     = row_start & (row_ff == '0);
   assign rend      = (column_ff >= col_last);
   assign lst       = rend & (row_ff >= row_last);
   assign desc      = cfg.control_one[C1_DESC];

   always_comb begin
      // pick fetched word, else holding register (seeded at blit start)
      hold_a_in  = cfg.control_zero[C0_USE_A] ? req_a_word :
                   (start ? cfg.a_preload : hold_a_ff);
      hold_b_in  = cfg.control_zero[C0_USE_B] ? req_b_word :
                   (start ? cfg.b_preload : hold_b_ff);
      hold_c_in  = cfg.control_zero[C0_USE_C] ? req_c_word :
                   (start ? cfg.c_preload : hold_c_ff);
      prev_a_eff = start ? cfg.a_preload : prev_a_ff;
      prev_b_eff = start ? cfg.b_preload : prev_b_ff;

      a_masked = hold_a_in;
      if (row_start) begin
         a_masked = a_masked & cfg.first_mask;
      end
      if (rend) begin
         a_masked = a_masked & cfg.last_mask;
      end
      prev_a_in = a_masked;
      prev_b_in = hold_b_in;

      push_item.a_val      = shift_pair(a_masked, prev_a_eff, cfg.control_zero[15:12], desc);
      push_item.b_val      = shift_pair(hold_b_in, prev_b_eff, cfg.control_one[15:12], desc);
      push_item.c_val      = hold_c_in;
      push_item.blit_start = start;
      push_item.row_start  = row_start;
      push_item.row_end    = rend;
      push_item.last       = lst;

      // advance position
      if (lst) begin
         column_in = '0;
         row_in    = '0;
      end else if (rend) begin
         column_in = '0;
         row_in    = row_ff + RowWidth'(1);
      end else begin
         column_in = column_ff + ColWidth'(1);
         row_in    = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         prev_a_ff <= '0;
         prev_b_ff <= '0;
         hold_a_ff <= '0;
         hold_b_ff <= '0;
         hold_c_ff <= '0;
      end else if (size_write) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else if (push) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         hold_a_ff <= hold_a_in;
         hold_b_ff <= hold_b_in;
         hold_c_ff <= hold_c_in;
      end
   end

endmodule

### rtl/bwd_queue.sv
// ----------------------------------------------------------------------------
// bwd_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module bwd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bwd_pkg::bwd_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output bwd_pkg::bwd_item_type head_item
);
   import bwd_pkg::*;

   bwd_item_type store_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push & ~pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop & ~push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

### rtl/bwd_back.sv
// ----------------------------------------------------------------------------
// bwd_back
// Minterm, area fill, zero tracking and the result register.
// ----------------------------------------------------------------------------
module bwd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bwd_pkg::bwd_cfg_type  cfg,
   input  logic                  head_valid,
   input  bwd_pkg::bwd_item_type head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_d_word,
   output logic                  rsp_d_write,
   output logic                  rsp_row_end,
   output logic                  rsp_last,
   output logic                  rsp_zero_flag
);
   import bwd_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 fill_bit_ff, fill_bit_in;
   logic                 zero_run_ff, zero_run_in;
   logic [WordWidth-1:0] d_ff, d_in;
   logic                 d_write_ff, row_end_ff, last_ff, zero_ff;
   logic [WordWidth-1:0] mt_word, carry_below;
   logic                 carry_start, fill_on;

   assign pop      = head_valid & (~valid_ff | ~rsp_stall);
   assign valid_in = pop | (valid_ff & rsp_stall);
   assign fill_on  = cfg.control_one[C1_INCL] | cfg.control_one[C1_EXCL];

   always_comb begin
      for (int i = 0; i < WordWidth; i++) begin
         mt_word[i] = cfg.control_zero[{head_item.a_val[i], head_item.b_val[i],
                                        head_item.c_val[i]}];
      end
      carry_start = head_item.row_start ? cfg.control_one[C1_FCI] : fill_bit_ff;
      // carry ahead of each bit: independent prefix parities
      for (int i = 0; i < WordWidth; i++) begin
         carry_below[i] = carry_start ^
                          (^(mt_word & ((WordWidth'(1) << i) - WordWidth'(1))));
      end
      if (cfg.control_one[C1_INCL]) begin
         d_in = carry_below | mt_word;
      end else if (cfg.control_one[C1_EXCL]) begin
         d_in = carry_below ^ mt_word;
      end else begin
         d_in = mt_word;
      end
      fill_bit_in = fill_on ? (carry_start ^ (^mt_word)) : carry_start;
      zero_run_in = (head_item.blit_start | zero_run_ff) & (d_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         fill_bit_ff <= 1'b0;
         zero_run_ff <= 1'b1;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            fill_bit_ff <= fill_bit_in;
            zero_run_ff <= zero_run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         d_ff       <= d_in;
         d_write_ff <= cfg.control_zero[C0_USE_D];
         row_end_ff <= head_item.row_end;
         last_ff    <= head_item.last;
         zero_ff    <= zero_run_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_d_word    = d_ff;
   assign rsp_d_write   = d_write_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_last      = last_ff;
   assign rsp_zero_flag = zero_ff;

endmodule

### rtl/blit_word_datapath_core.sv
// ----------------------------------------------------------------------------
// blit_word_datapath_core
// Blitter word datapath: mask, shift, minterm and area fill, one D word out
// for every fetched A/B/C word set.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------------
//   req      | in        | req_valid/req_stall | a, b, c words
//   rsp      | out       | rsp_valid/rsp_stall | d word, write, row end, last, zero
//   csr      | in        | csr_write           | csr_index, csr_data
//
// One word per clock sustained while rsp_stall stays low. The front shifts
// an accepted word into the queue at the accepting edge; the back pops it,
// runs the minterm and fill and loads the result register unless a valid
// result there is held by rsp_stall.
// The front stalls only when the two-entry queue is full; the back holds its
// result register while it is valid and rsp_stall is high, keeps draining otherwise.
// Synchronous reset clears the position, holding registers, queue and valid.
//
module blit_word_datapath_core (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_a_word,
   input  logic [15:0] req_b_word,
   input  logic [15:0] req_c_word,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_d_word,
   output logic        rsp_d_write,
   output logic        rsp_row_end,
   output logic        rsp_last,
   output logic        rsp_zero_flag,
   // register writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bwd_pkg::*;

   bwd_cfg_type  cfg_ff;
   bwd_item_type push_item, head_item;
   logic         push, pop, queue_full, head_valid, size_write;
   bwd_reg_type  reg_sel;

   assign reg_sel    = bwd_reg_type'(csr_index);
   assign size_write = csr_write & (reg_sel == REG_BLIT_SIZE);

   // Register file: decode the index and store the data word.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_zero <= '0;
         cfg_ff.control_one  <= '0;
         cfg_ff.first_mask   <= '1;
         cfg_ff.last_mask    <= '1;
         cfg_ff.blit_size    <= '0;
         cfg_ff.a_preload    <= '0;
         cfg_ff.b_preload    <= '0;
         cfg_ff.c_preload    <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            REG_CONTROL_ZERO: cfg_ff.control_zero <= csr_data;
            REG_CONTROL_ONE:  cfg_ff.control_one  <= csr_data;
            REG_FIRST_MASK:   cfg_ff.first_mask   <= csr_data;
            REG_LAST_MASK:    cfg_ff.last_mask    <= csr_data;
            REG_BLIT_SIZE:    cfg_ff.blit_size    <= csr_data;
            REG_A_PRELOAD:    cfg_ff.a_preload    <= csr_data;
            REG_B_PRELOAD:    cfg_ff.b_preload    <= csr_data;
            REG_C_PRELOAD:    cfg_ff.c_preload    <= csr_data;
            default: ;
         endcase
      end
   end

   // Hold off new words only while the queue has no room.
   assign req_stall = queue_full;

   // Front: position, holding registers, masking and barrel shift.
   bwd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .size_write (size_write),
      .req_valid  (req_valid),
      .req_a_word (req_a_word),
      .req_b_word (req_b_word),
      .req_c_word (req_c_word),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // Queue: decouple the front from result back-pressure.
   bwd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Back: minterm, fill, zero flag and result register.
   bwd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_d_word    (rsp_d_word),
      .rsp_d_write   (rsp_d_write),
      .rsp_row_end   (rsp_row_end),
      .rsp_last      (rsp_last),
      .rsp_zero_flag (rsp_zero_flag)
   );

endmodule

### rtl/bwd_checker.sv
// ----------------------------------------------------------------------------
// bwd_checker
// Port-level checks of the blit word datapath, bound to the top level.
// ----------------------------------------------------------------------------
module bwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_d_word,
   input logic        rsp_row_end,
   input logic        rsp_last,
   input logic        rsp_zero_flag
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_d_word) && $stable(rsp_last))
      else $error("stalled result changed");

   // the blit end is always a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_row_end)
      else $error("last without row end");

   // a nonzero word clears the zero flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_d_word != 16'h0000) |-> !rsp_zero_flag)
      else $error("zero flag set on nonzero word");

   // nothing comes out right after reset
   assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind blit_word_datapath_core bwd_checker u_bwd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_d_word    (rsp_d_word),
   .rsp_row_end   (rsp_row_end),
   .rsp_last      (rsp_last),
   .rsp_zero_flag (rsp_zero_flag)
);

### bench/blit_word_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blit_word_checker
// Watches the word, result and register ports of the blit datapath, predicts
// the D word for every accepted input word and compares each accepted result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module blit_word_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_a_word,
   input  logic [15:0] req_b_word,
   input  logic [15:0] req_c_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_d_word,
   input  logic        rsp_d_write,
   input  logic        rsp_row_end,
   input  logic        rsp_last,
   input  logic        rsp_zero_flag,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          words_in_flight,
   output int          mismatch_count
);
   import bwd_pkg::*;

   typedef struct packed {
      logic [WordWidth-1:0] d_word;
      logic                 d_write;
      logic                 row_end;
      logic                 last;
      logic                 zero_flag;
   } d_word_result_type;

   d_word_result_type pending_d_words [$];
   int                errors = 0;

   // shadow registers and datapath state
   bit [WordWidth-1:0] regs [0:7];
   bit [WordWidth-1:0] prev_a, prev_b, hold_a, hold_b, hold_c;
   bit                 fill_bit, zero_run;
   bit [ColWidth-1:0]  column;
   bit [RowWidth-1:0]  row;

   function automatic void clear_shadow();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_FIRST_MASK] = 16'hFFFF;
      regs[REG_LAST_MASK]  = 16'hFFFF;
      prev_a = '0; prev_b = '0;
      hold_a = '0; hold_b = '0; hold_c = '0;
      fill_bit = 1'b0;
      zero_run = 1'b1;
      column = '0;
      row    = '0;
   endfunction

   // Funnel shift of the current word against the previous one.
   function automatic bit [15:0] shift_pair(bit [15:0] cur, bit [15:0] old, bit [3:0] sh,
                                            bit desc);
      bit [31:0] pair;
      if (sh == 0) return cur;
      if (desc) begin
         pair = {cur, old} >> (16 - sh);
      end else begin
         pair = {old, cur} >> sh;
      end
      return pair[15:0];
   endfunction

   function automatic bit [15:0] combine_minterm(bit [15:0] a, bit [15:0] b, bit [15:0] c,
                                                 bit [7:0] mt);
      bit [15:0] r;
      int        k;
      r = '0;
      for (k = 0; k < 8; k++) begin
         if (mt[k]) r |= (k[2] ? a : ~a) & (k[1] ? b : ~b) & (k[0] ? c : ~c);
      end
      return r;
   endfunction

   function automatic d_word_result_type next_d_word(bit [15:0] a_in, bit [15:0] b_in,
                                                     bit [15:0] c_in);
      bit [15:0]         cz, c1, a_val, shifted_a, shifted_b, d, filled;
      bit                desc, at_row_end, at_last, carry_before;
      int                words_per_row, rows_per_blit, i;
      d_word_result_type res;
      cz   = regs[REG_CONTROL_ZERO];
      c1   = regs[REG_CONTROL_ONE];
      desc = c1[C1_DESC];
      words_per_row = int'(regs[REG_BLIT_SIZE][5:0]);
      rows_per_blit = int'(regs[REG_BLIT_SIZE][15:6]);
      if (words_per_row == 0) words_per_row = 64;
      if (rows_per_blit == 0) rows_per_blit = 1024;

      if (column == 0 && row == 0) begin
         hold_a = regs[REG_A_PRELOAD]; prev_a = hold_a;
         hold_b = regs[REG_B_PRELOAD]; prev_b = hold_b;
         hold_c = regs[REG_C_PRELOAD];
         zero_run = 1'b1;
      end
      if (column == 0) fill_bit = c1[C1_FCI];

      at_row_end = int'(column) >= words_per_row - 1;
      at_last    = at_row_end && int'(row) >= rows_per_blit - 1;

      if (cz[C0_USE_A]) hold_a = a_in;
      if (cz[C0_USE_B]) hold_b = b_in;
      if (cz[C0_USE_C]) hold_c = c_in;

      a_val = hold_a;
      if (column == 0) a_val &= regs[REG_FIRST_MASK];
      if (at_row_end)  a_val &= regs[REG_LAST_MASK];
      shifted_a = shift_pair(a_val, prev_a, cz[15:12], desc);
      prev_a    = a_val;
      shifted_b = shift_pair(hold_b, prev_b, c1[15:12], desc);
      prev_b    = hold_b;

      d = combine_minterm(shifted_a, shifted_b, hold_c, cz[7:0]);
      // fill walks upward from bit 0; inclusive wins over exclusive
      if (c1[C1_INCL] || c1[C1_EXCL]) begin
         filled = '0;
         for (i = 0; i < 16; i++) begin
            carry_before = fill_bit;
            fill_bit     = fill_bit ^ d[i];
            filled[i]    = c1[C1_INCL] ? (carry_before | d[i]) : fill_bit;
         end
         d = filled;
      end
      if (d != 0) zero_run = 1'b0;

      res.d_word    = d;
      res.d_write   = cz[C0_USE_D];
      res.row_end   = at_row_end;
      res.last      = at_last;
      res.zero_flag = zero_run;

      if (at_last) begin
         column = '0;
         row    = '0;
      end else if (at_row_end) begin
         column = '0;
         row    = row + 1'b1;
      end else begin
         column = column + 1'b1;
      end
      return res;
   endfunction

   function automatic void check_field(string name, bit [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      d_word_result_type want;
      if (reset) begin
         clear_shadow();
         pending_d_words.delete();
      end else begin
         if (csr_write) begin
            regs[csr_index] = csr_data;
            if (csr_index == REG_BLIT_SIZE) begin
               column = '0;
               row    = '0;
            end
         end
         if (req_valid && !req_stall)
            pending_d_words.push_back(next_d_word(req_a_word, req_b_word, req_c_word));
         if (rsp_valid && !rsp_stall) begin
            if (pending_d_words.size() == 0) begin
               $error("d_word: expected none, actual %h", rsp_d_word);
               errors++;
            end else begin
               want = pending_d_words.pop_front();
               check_field("d_word", want.d_word, rsp_d_word);
               check_field("d_write", 16'(want.d_write), 16'(rsp_d_write));
               check_field("row_end", 16'(want.row_end), 16'(rsp_row_end));
               check_field("last", 16'(want.last), 16'(rsp_last));
               check_field("zero_flag", 16'(want.zero_flag), 16'(rsp_zero_flag));
            end
         end
      end
      words_in_flight <= pending_d_words.size();
      mismatch_count  <= errors;
   end

endmodule

### bench/blit_word_datapath_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blit_word_datapath_core_tb
// Drives fetched A/B/C words into the blit datapath under bursty input and a
// stalling receiver, programs a series of blit setups between phases, and
// lets the checker predict and compare every D word.
// ----------------------------------------------------------------------------
module blit_word_datapath_core_tb;
   import bwd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_a_word = '0;
   logic [15:0] req_b_word = '0;
   logic [15:0] req_c_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_d_word;
   logic        rsp_d_write;
   logic        rsp_row_end;
   logic        rsp_last;
   logic        rsp_zero_flag;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int words_in_flight;
   int mismatch_count;
   int words_sent = 0;
   int burst_left = 0;
   int long_hold_requests = 0;

   always #5 clock = ~clock;

   blit_word_datapath_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_a_word    (req_a_word),
      .req_b_word    (req_b_word),
      .req_c_word    (req_c_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_d_word    (rsp_d_word),
      .rsp_d_write   (rsp_d_write),
      .rsp_row_end   (rsp_row_end),
      .rsp_last      (rsp_last),
      .rsp_zero_flag (rsp_zero_flag),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   blit_word_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_a_word      (req_a_word),
      .req_b_word      (req_b_word),
      .req_c_word      (req_c_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_d_word      (rsp_d_word),
      .rsp_d_write     (rsp_d_write),
      .rsp_row_end     (rsp_row_end),
      .rsp_last        (rsp_last),
      .rsp_zero_flag   (rsp_zero_flag),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .words_in_flight (words_in_flight),
      .mismatch_count  (mismatch_count)
   );

   // ------------------------------------------------------------------------
   // Receiver: cycle through stall patterns of random length (free running,
   // light, heavy, periodic). A long hold request from the stimulus side
   // overrides the pattern and holds rsp_stall high for a fixed stretch so
   // the core's queue fills and it pushes back on the input.
   // ------------------------------------------------------------------------
   int stall_mode = 0;
   int mode_left  = 0;
   int hold_left  = 0;
   int holds_served = 0;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_served != long_hold_requests) begin
         holds_served <= long_hold_requests;
         hold_left    <= 48;
         rsp_stall    <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(8, 60);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= (mode_left % 3 == 0);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers. Every task is entered right after a rising edge and
   // leaves right after one, so each drive below lands in a fresh time step.
   // ------------------------------------------------------------------------

   // Drop valid, then hold until the checker has seen every D word come back.
   // The first edge lets a word accepted in this step reach the checker.
   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_reg(bwd_reg_type idx, bit [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // Program a whole blit setup while the core is empty. Skipping the size
   // write leaves the position where the last phase stopped, so the next
   // words continue mid-row under the new setup.
   task automatic program_blit(bit [15:0] cz, bit [15:0] c1, bit [15:0] first_mask,
                               bit [15:0] last_mask, bit [15:0] size, bit [15:0] a_pre,
                               bit [15:0] b_pre, bit [15:0] c_pre, bit load_size);
      wait_idle();
      write_reg(REG_CONTROL_ZERO, cz);
      write_reg(REG_CONTROL_ONE, c1);
      write_reg(REG_FIRST_MASK, first_mask);
      write_reg(REG_LAST_MASK, last_mask);
      write_reg(REG_A_PRELOAD, a_pre);
      write_reg(REG_B_PRELOAD, b_pre);
      write_reg(REG_C_PRELOAD, c_pre);
      if (load_size) write_reg(REG_BLIT_SIZE, size);
      csr_write <= 1'b0;
   endtask

   // Offer one word and hold it until the core takes it. Valid stays high
   // into the next word unless the current burst is used up, in which case
   // drop valid for a short random gap.
   task automatic send_word(bit [15:0] a, bit [15:0] b, bit [15:0] c);
      req_valid  <= 1'b1;
      req_a_word <= a;
      req_b_word <= b;
      req_c_word <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Bias toward all-zero, all-one and single-bit patterns for the mask,
   // shift and fill edges; plain random otherwise.
   function automatic bit [15:0] pick_word();
      bit [15:0] one_hot;
      one_hot = 16'h0001 << $urandom_range(0, 15);
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return one_hot;
         3:       return ~one_hot;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bit [15:0] pick_reg();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int        phase_no;
      int        word_count;
      int        words_per_row;
      bit [5:0]  width_f;
      bit [9:0]  rows_f;
      bit [15:0] cz, c1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---------------------------------------------------

      // Out of reset: no channel enabled, minterm zero, full-size blit.
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'h0000, 16'h0000, 16'h0000);

      // Ascending 3x2 blit, both shifts active, masks on first and last word,
      // minterm "A ? B : C". Runs exactly one blit to its last word.
      program_blit(16'h4FCA, 16'h5000, 16'hFF00, 16'h00FF, {10'd2, 6'd3},
                   16'h8001, 16'hFFFF, 16'h5A5A, 1'b1);
      send_word(16'hFFFF, 16'h0000, 16'hFFFF);
      send_word(16'h0000, 16'hFFFF, 16'h0000);
      send_word(16'h8000, 16'h0001, 16'hFFFF);
      send_word(16'h0001, 16'h8000, 16'h0000);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'h0000, 16'h0000, 16'h0000);

      // Descending, widest A shift, inclusive fill with carry in, XOR minterm.
      program_blit(16'hFF96, 16'h300E, 16'hFFFF, 16'hFFFF, {10'd1, 6'd2},
                   16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_word(16'h0010, 16'h0000, 16'h0000);
      send_word(16'h0000, 16'h0000, 16'h0000);
      send_word(16'h8001, 16'h0100, 16'hFFFF);
      send_word(16'h0000, 16'h8000, 16'h0001);

      // All channels disabled: holding registers from the preloads feed the
      // datapath; exclusive fill; D not written.
      program_blit(16'h00F0, 16'h0012, 16'hFFFF, 16'hFFFF, {10'd2, 6'd1},
                   16'h0810, 16'h1234, 16'hF00F, 1'b1);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'h0000, 16'h0000, 16'h0000);
      send_word(16'hAAAA, 16'h5555, 16'hAAAA);

      // Everything at its top: both fill bits (inclusive wins), all control bits
      // set, all-ones size field, masks cleared.
      program_blit(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_word(16'h0000, 16'hFFFF, 16'h0000);
      send_word(16'hFFFF, 16'h0000, 16'hFFFF);
      send_word(16'h7FFE, 16'h8001, 16'h0F0F);
      send_word(16'h0001, 16'h0002, 16'h0004);

      // Everything at zero: the zero flag must stay set across the words.
      program_blit(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_word(16'h1111, 16'h2222, 16'h4444);
      send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(16'h0000, 16'h0000, 16'h0000);

      // --- random part -----------------------------------------------------
      for (phase_no = 0; words_sent < 1230; phase_no++) begin
         cz = 16'($urandom);
         cz[C0_USE_A] = ($urandom_range(0, 4) != 0);
         cz[C0_USE_B] = ($urandom_range(0, 4) != 0);
         cz[C0_USE_C] = ($urandom_range(0, 4) != 0);
         c1 = 16'($urandom);

         if ($urandom_range(0, 11) == 0) begin
            // big blit: only part of it runs, but row ends at 64 and 63 words
            // and the row count extremes get exercised
            case ($urandom_range(0, 2))
               0:       width_f = 6'd0;
               1:       width_f = 6'd63;
               default: width_f = 6'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       rows_f = 10'd0;
               1:       rows_f = 10'd1;
               2:       rows_f = 10'd1023;
               default: rows_f = 10'($urandom);
            endcase
            word_count = $urandom_range(20, 70);
         end else begin
            words_per_row = $urandom_range(1, 6);
            width_f       = 6'(words_per_row);
            rows_f        = 10'($urandom_range(1, 4));
            word_count    = words_per_row * int'(rows_f) + $urandom_range(0, 2);
         end

         program_blit(cz, c1, ($urandom_range(0, 1) != 0) ? 16'hFFFF : pick_reg(),
                      ($urandom_range(0, 1) != 0) ? 16'hFFFF : pick_reg(),
                      {rows_f, width_f}, pick_reg(), pick_reg(), pick_reg(),
                      $urandom_range(0, 4) != 0);

         // Some phases run without input gaps at all.
         if ($urandom_range(0, 2) == 0) burst_left = 1 << 20;
         else burst_left = $urandom_range(1, 24);

         // Now and then hold the receiver off for a long stretch while words
         // keep coming, so the queue fills and the core stalls its input.
         if (phase_no % 12 == 3) begin
            long_hold_requests <= long_hold_requests + 1;
            burst_left = 1 << 20;
            if (word_count < 30) word_count = 30;
         end

         repeat (word_count) send_word(pick_word(), pick_word(), pick_word());
      end

      // Drain the two-stage pipeline, then judge.
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
rtl/bwd_pkg.sv
rtl/bwd_front.sv
rtl/bwd_queue.sv
rtl/bwd_back.sv
rtl/blit_word_datapath_core.sv
rtl/bwd_checker.sv
bench/blit_word_checker.sv
bench/blit_word_datapath_core_tb.sv
